/* rtl/rpdf_pkg.sv */
// Package for the reliable packet dedup and forward unit.
// Holds the character codes, action codes and the structs shared between modules.
// No dependencies.
package rpdf_pkg;

    // Header characters.
    localparam logic [7:0] CH_FORWARD = 8'h46;  // 'F'
    localparam logic [7:0] CH_BATTERY = 8'h42;  // 'B'
    localparam logic [7:0] CH_TEMP    = 8'h54;  // 'T'
    localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE     = 8'h31;  // '1'

    // Side length of the child grid; digit values at or above it are rejected unless they match this node's address.
    localparam int unsigned CHILD_GRID = 10;

    // Configuration register indexes (byte address is four times the index).
    localparam logic REG_OWN_ADDR_HIGH = 1'b0;
    localparam logic REG_OWN_ADDR_LOW  = 1'b1;

    typedef enum logic [2:0] {
        ACT_DUPLICATE  = 3'd0,
        ACT_LOCAL      = 3'd1,
        ACT_CHILD      = 3'd2,
        ACT_PARENT     = 3'd3,
        ACT_BAD_CHILD  = 3'd4
    } action_t;

    typedef struct packed {
        logic [7:0] own_addr_high;
        logic [7:0] own_addr_low;
    } cfg_t;

    typedef struct packed {
        logic [15:0] src_addr;
        logic [7:0]  seq_num;
        logic [7:0]  kind_byte;
        logic [7:0]  row_char;
        logic [7:0]  col_char;
        logic [7:0]  channel_char;
        logic [7:0]  value_char;
    } in_item_t;

    typedef struct packed {
        action_t    action;
        logic [3:0] forward_row;
        logic [3:0] forward_col;
        logic       battery_subscribed;
        logic       temp_subscribed;
    } out_item_t;

    // Lookup result of the history table for the request under work.
    typedef struct packed {
        logic hit;
        logic dup;
    } hist_status_t;

endpackage

/* rtl/rpdf_in_if.sv */
// Request channel of the reliable packet dedup and forward unit.
// Carries one received packet header with valid/ready handshake; no dependencies.
interface rpdf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] src_addr;
    logic [7:0]  seq_num;
    logic [7:0]  kind_byte;
    logic [7:0]  row_char;
    logic [7:0]  col_char;
    logic [7:0]  channel_char;
    logic [7:0]  value_char;

    modport source (
        output valid, src_addr, seq_num, kind_byte, row_char, col_char,
               channel_char, value_char,
        input  ready
    );

    modport sink (
        input  valid, src_addr, seq_num, kind_byte, row_char, col_char,
               channel_char, value_char,
        output ready
    );
endinterface

/* rtl/rpdf_out_if.sv */
// Result channel of the reliable packet dedup and forward unit.
// Carries one routing decision with valid/ready handshake; no dependencies.
interface rpdf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [3:0] forward_row;
    logic [3:0] forward_col;
    logic       battery_subscribed;
    logic       temp_subscribed;

    modport source (
        output valid, action, forward_row, forward_col, battery_subscribed,
               temp_subscribed,
        input  ready
    );

    modport sink (
        input  valid, action, forward_row, forward_col, battery_subscribed,
               temp_subscribed,
        output ready
    );
endinterface

/* rtl/reliable_packet_dedup_and_forward_unit.sv */
// Reliable packet dedup and forward unit: a request passes the input register,
// then the result register, before its result is valid; one request per cycle
// while the receiver takes results. Throughput is set by the history match and
// update, which finishes before the next request reaches the decision logic.
// rst_n clears the history valid bits, the refill pointer, the subscription
// flags, the own-address registers and both pipeline valid bits; no clearing pass.
module reliable_packet_dedup_and_forward_unit
#(
    parameter int unsigned HISTORY_DEPTH = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    rpdf_in_if.sink           in_ch,
    rpdf_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    rpdf_pkg::cfg_t           cfg;
    rpdf_pkg::hist_status_t   hist_status;

    // Input stage: holds one accepted request until the decision logic takes it.
    logic                     in_valid_reg;
    logic                     in_valid_next;
    rpdf_pkg::in_item_t       in_item_reg;

    // Result stage.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    rpdf_pkg::out_item_t      out_item_reg;
    rpdf_pkg::out_item_t      out_item_next;

    // Subscription flags.
    logic                     battery_flag_reg;
    logic                     battery_flag_next;
    logic                     temp_flag_reg;
    logic                     temp_flag_next;

    logic                     in_take;
    logic                     advance;

    logic                     row_ok;
    logic                     col_ok;
    logic [7:0]               row_val;
    logic [7:0]               col_val;
    logic                     to_self;
    logic                     to_child;

    rpdf_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The request in the input stage is decided when the result register is
    // empty or its current result is being taken in the same cycle. The
    // history is updated at that same edge, so the next request sees it.
    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign in_take      = in_ch.valid && in_ch.ready;

    rpdf_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .lookup_sender (in_item_reg.src_addr),
        .lookup_seq    (in_item_reg.seq_num),
        .commit        (advance),
        .status        (hist_status)
    );

    // Target digits are the characters minus '0'; a character below '0' is
    // never a valid digit, and the subtraction cannot wrap once it is checked.
    assign row_ok   = in_item_reg.row_char >= rpdf_pkg::CH_ZERO;
    assign col_ok   = in_item_reg.col_char >= rpdf_pkg::CH_ZERO;
    assign row_val  = in_item_reg.row_char - rpdf_pkg::CH_ZERO;
    assign col_val  = in_item_reg.col_char - rpdf_pkg::CH_ZERO;
    assign to_self  = row_ok && col_ok && (row_val == cfg.own_addr_high)
                      && (col_val == cfg.own_addr_low);
    assign to_child = row_ok && col_ok && (row_val < 8'(rpdf_pkg::CHILD_GRID))
                      && (col_val < 8'(rpdf_pkg::CHILD_GRID));

    always_comb
    begin
        battery_flag_next         = battery_flag_reg;
        temp_flag_next            = temp_flag_reg;
        out_item_next.forward_row = 4'd0;
        out_item_next.forward_col = 4'd0;

        priority if (hist_status.dup)
        begin
            // A repeated sequence number from a known sender changes nothing.
            out_item_next.action = rpdf_pkg::ACT_DUPLICATE;
        end
        else if (in_item_reg.kind_byte != rpdf_pkg::CH_FORWARD)
        begin
            out_item_next.action = rpdf_pkg::ACT_PARENT;
        end
        else if (to_self)
        begin
            // A command for this node: an unknown channel or value is still
            // consumed but leaves both flags alone.
            out_item_next.action = rpdf_pkg::ACT_LOCAL;
            if (in_item_reg.channel_char == rpdf_pkg::CH_BATTERY)
            begin
                if (in_item_reg.value_char == rpdf_pkg::CH_ZERO)
                    battery_flag_next = 1'b0;
                else if (in_item_reg.value_char == rpdf_pkg::CH_ONE)
                    battery_flag_next = 1'b1;
            end
            else if (in_item_reg.channel_char == rpdf_pkg::CH_TEMP)
            begin
                if (in_item_reg.value_char == rpdf_pkg::CH_ZERO)
                    temp_flag_next = 1'b0;
                else if (in_item_reg.value_char == rpdf_pkg::CH_ONE)
                    temp_flag_next = 1'b1;
            end
        end
        else if (to_child)
        begin
            out_item_next.action      = rpdf_pkg::ACT_CHILD;
            out_item_next.forward_row = row_val[3:0];
            out_item_next.forward_col = col_val[3:0];
        end
        else
        begin
            // A digit outside the grid is flagged rather than routed.
            out_item_next.action = rpdf_pkg::ACT_BAD_CHILD;
        end

        out_item_next.battery_subscribed = battery_flag_next;
        out_item_next.temp_subscribed    = temp_flag_next;
    end

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            battery_flag_reg <= 1'b0;
            temp_flag_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                battery_flag_reg <= battery_flag_next;
                temp_flag_reg    <= temp_flag_next;
            end
        end
    end

    // Payload registers load only on their handshakes and need no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.src_addr     <= in_ch.src_addr;
            in_item_reg.seq_num      <= in_ch.seq_num;
            in_item_reg.kind_byte    <= in_ch.kind_byte;
            in_item_reg.row_char     <= in_ch.row_char;
            in_item_reg.col_char     <= in_ch.col_char;
            in_item_reg.channel_char <= in_ch.channel_char;
            in_item_reg.value_char   <= in_ch.value_char;
        end
        if (advance)
            out_item_reg <= out_item_next;
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.action             = out_item_reg.action;
    assign out_ch.forward_row        = out_item_reg.forward_row;
    assign out_ch.forward_col        = out_item_reg.forward_col;
    assign out_ch.battery_subscribed = out_item_reg.battery_subscribed;
    assign out_ch.temp_subscribed    = out_item_reg.temp_subscribed;

endmodule

/* rtl/rpdf_apb_regs.sv */
// APB configuration registers: this node's two address bytes.
// Depends on rpdf_pkg.
module rpdf_apb_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output rpdf_pkg::cfg_t    cfg
);

    logic [7:0] own_addr_high_reg;
    logic [7:0] own_addr_low_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_high_reg <= 8'd0;
            own_addr_low_reg  <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                rpdf_pkg::REG_OWN_ADDR_HIGH: own_addr_high_reg <= pwdata[7:0];
                rpdf_pkg::REG_OWN_ADDR_LOW:  own_addr_low_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rpdf_pkg::REG_OWN_ADDR_HIGH: prdata = {24'd0, own_addr_high_reg};
            rpdf_pkg::REG_OWN_ADDR_LOW:  prdata = {24'd0, own_addr_low_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    assign cfg.own_addr_high = own_addr_high_reg;
    assign cfg.own_addr_low  = own_addr_low_reg;

endmodule

/* rtl/rpdf_history.sv */
// Sender history table: parallel sender match, duplicate check and round-robin refill.
// Depends on rpdf_pkg.
module rpdf_history
#(
    parameter int unsigned HISTORY_DEPTH = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [15:0]            lookup_sender,
    input  logic [7:0]             lookup_seq,
    input  logic                   commit,
    output rpdf_pkg::hist_status_t status
);

    localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    logic [15:0]              hist_sender_reg [HISTORY_DEPTH];
    logic [7:0]               hist_seq_reg    [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hist_valid_reg;
    logic [HISTORY_DEPTH-1:0] hist_valid_next;
    logic [SLOT_W-1:0]        oldest_slot_reg;
    logic [SLOT_W-1:0]        oldest_slot_next;

    logic [HISTORY_DEPTH-1:0] match;
    logic [7:0]               hit_seq;

    // Stored senders are unique among valid entries, so at most one entry
    // matches and the stored sequence number can be gathered by OR.
    always_comb
    begin
        hit_seq = 8'd0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            match[i] = hist_valid_reg[i] && (hist_sender_reg[i] == lookup_sender);
            hit_seq  = hit_seq | (match[i] ? hist_seq_reg[i] : 8'd0);
        end
    end

    assign status.hit = |match;
    assign status.dup = (|match) && (hit_seq == lookup_seq);

    always_comb
    begin
        hist_valid_next  = hist_valid_reg;
        oldest_slot_next = oldest_slot_reg;
        if (commit && !status.hit)
        begin
            hist_valid_next[oldest_slot_reg] = 1'b1;
            oldest_slot_next = (oldest_slot_reg == LAST_SLOT) ? '0 : oldest_slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg  <= '0;
            oldest_slot_reg <= '0;
        end
        else
        begin
            hist_valid_reg  <= hist_valid_next;
            oldest_slot_reg <= oldest_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if (commit && !status.hit && (oldest_slot_reg == SLOT_W'(i)))
            begin
                hist_sender_reg[i] <= lookup_sender;
                hist_seq_reg[i]    <= lookup_seq;
            end
            else if (commit && match[i] && !status.dup)
            begin
                hist_seq_reg[i] <= lookup_seq;
            end
        end
    end

endmodule

/* sim/tb_reliable_packet_dedup_and_forward_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the reliable packet dedup and forward unit.
// Depends on rpdf_pkg, the rpdf_in_if / rpdf_out_if interfaces and the unit itself.
module tb_reliable_packet_dedup_and_forward_unit;
    import rpdf_pkg::*;

    localparam int unsigned HIST_DEPTH       = 10;
    localparam int          RANDOM_PER_PHASE = 250;
    localparam int          PHASE_COUNT      = 7;
    localparam int          HOLD_OFF_CYCLES  = 300;
    localparam int          DRAIN_CYCLES     = 10;
    localparam int          CYCLE_LIMIT      = 400000;
    localparam int          MAX_PRINTED      = 100;

    // One row of the directed part. Where the outcome is obvious from the
    // header alone, the expected decision is typed in; other rows rely on
    // the routing predictor below.
    typedef struct packed {
        in_item_t  req;
        logic      typed;
        out_item_t want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rpdf_in_if  in_ch();
    rpdf_out_if out_ch();

    reliable_packet_dedup_and_forward_unit #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock: five high, five low.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the unit's state, kept by the routing predictor.
    logic [15:0] seen_sender [HIST_DEPTH];
    logic [7:0]  seen_seq    [HIST_DEPTH];
    logic        seen_valid  [HIST_DEPTH];
    int unsigned refill_slot;
    logic        battery_on;
    logic        temp_on;
    logic [7:0]  node_high;
    logic [7:0]  node_low;

    // Decisions predicted for accepted requests, oldest first.
    out_item_t     pending_decisions[$];
    directed_row_t directed_rows[$];
    logic [15:0]   sender_pool[16];

    int mismatch_count;
    int burst_left;
    bit hold_off_req;

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got,
                               input logic [3:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Works out the decision for one accepted request and updates the shadow
    // state exactly as the unit should: history lookup first, then either a
    // duplicate drop or routing on the forward command fields.
    function automatic out_item_t predict_route(input in_item_t r);
        out_item_t  d;
        int         hit;
        logic       row_ok;
        logic       col_ok;
        logic [7:0] row_val;
        logic [7:0] col_val;
        d   = '0;
        hit = -1;
        for (int i = 0; i < HIST_DEPTH; i++)
            if (hit < 0 && seen_valid[i] && seen_sender[i] == r.src_addr)
                hit = i;

        if (hit >= 0 && seen_seq[hit] == r.seq_num)
        begin
            // Duplicate: neither history nor flags move.
            d.action = ACT_DUPLICATE;
        end
        else
        begin
            if (hit < 0)
            begin
                // Unknown sender takes the oldest slot, round robin.
                seen_sender[refill_slot] = r.src_addr;
                seen_seq[refill_slot]    = r.seq_num;
                seen_valid[refill_slot]  = 1'b1;
                refill_slot = (refill_slot + 1) % HIST_DEPTH;
            end
            else
                seen_seq[hit] = r.seq_num;

            if (r.kind_byte == CH_FORWARD)
            begin
                // Digits below '0' are invalid; the subtraction wraps in 8 bits
                // but is only trusted when the character is at least '0'.
                row_ok  = r.row_char >= CH_ZERO;
                col_ok  = r.col_char >= CH_ZERO;
                row_val = r.row_char - CH_ZERO;
                col_val = r.col_char - CH_ZERO;
                if (row_ok && col_ok && row_val == node_high && col_val == node_low)
                begin
                    // Addressed to this node. Unknown channel or value
                    // characters leave both flags as they are.
                    if (r.channel_char == CH_BATTERY)
                    begin
                        if (r.value_char == CH_ZERO)
                            battery_on = 1'b0;
                        else if (r.value_char == CH_ONE)
                            battery_on = 1'b1;
                    end
                    else if (r.channel_char == CH_TEMP)
                    begin
                        if (r.value_char == CH_ZERO)
                            temp_on = 1'b0;
                        else if (r.value_char == CH_ONE)
                            temp_on = 1'b1;
                    end
                    d.action = ACT_LOCAL;
                end
                else if (row_ok && col_ok && row_val < CHILD_GRID && col_val < CHILD_GRID)
                begin
                    d.action      = ACT_CHILD;
                    d.forward_row = row_val[3:0];
                    d.forward_col = col_val[3:0];
                end
                else
                    d.action = ACT_BAD_CHILD;
            end
            else
                d.action = ACT_PARENT;
        end
        d.battery_subscribed = battery_on;
        d.temp_subscribed    = temp_on;
        return d;
    endfunction

    function automatic void add_row(input logic [15:0] src, input logic [7:0] seq,
                                    input logic [7:0] kind, input logic [7:0] rowc,
                                    input logic [7:0] colc, input logic [7:0] chan,
                                    input logic [7:0] val, input logic typed,
                                    input out_item_t want);
        directed_row_t row;
        row.req   = '{src, seq, kind, rowc, colc, chan, val};
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Offers one request, honoring the sender's burst/gap pattern, and records
    // the expected decision once the unit takes it. Called at a falling edge.
    task automatic send_request(input in_item_t r, input logic typed,
                                input out_item_t want);
        out_item_t predicted;
        if (burst_left == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            // Now and then a long burst, so that stretches with no gaps occur.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.src_addr     = r.src_addr;
        in_ch.seq_num      = r.seq_num;
        in_ch.kind_byte    = r.kind_byte;
        in_ch.row_char     = r.row_char;
        in_ch.col_char     = r.col_char;
        in_ch.channel_char = r.channel_char;
        in_ch.value_char   = r.value_char;
        in_ch.valid        = 1'b1;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predicted = predict_route(r);
        pending_decisions.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Drops valid and waits until every expected decision has come back.
    task automatic drain_decisions();
        in_ch.valid = 1'b0;
        while (pending_decisions.size() != 0)
            @(negedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_register(input logic idx, input logic [7:0] want);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd !== {24'd0, want})
            report_mismatch($sformatf("register %0d read %0h want %0h", idx, rd, want));
    endtask

    // Writes both address bytes (with junk in the unused upper bits, which the
    // unit must drop) and reads them back.
    task automatic set_own_addr(input logic [7:0] high, input logic [7:0] low);
        logic [31:0] junk;
        logic [31:0] rd;
        junk = $urandom();
        apb_access(1'b1, REG_OWN_ADDR_HIGH, {junk[31:8], high}, rd);
        junk = $urandom();
        apb_access(1'b1, REG_OWN_ADDR_LOW, {junk[31:8], low}, rd);
        node_high = high;
        node_low  = low;
        check_register(REG_OWN_ADDR_HIGH, high);
        check_register(REG_OWN_ADDR_LOW, low);
    endtask

    // Random header. Senders come mostly from a small pool so that the history
    // hits, misses and evicts; some requests replay a stored entry exactly to
    // force duplicates. Most headers are forward commands with plausible
    // digits, the rest is noise.
    function automatic in_item_t make_random_request();
        in_item_t    r;
        int unsigned slot;
        int unsigned pick;
        r = '0;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, HIST_DEPTH - 1);
        if (pick < 15 && seen_valid[slot])
        begin
            r.src_addr = seen_sender[slot];
            r.seq_num  = seen_seq[slot];
        end
        else
        begin
            r.src_addr = (pick < 85) ? sender_pool[$urandom_range(0, 15)]
                                     : 16'($urandom());
            r.seq_num  = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, 3))
                                                    : 8'($urandom());
        end

        pick = $urandom_range(0, 99);
        r.kind_byte = (pick < 70) ? CH_FORWARD : 8'($urandom());

        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            r.row_char = node_high + CH_ZERO;
            r.col_char = node_low + CH_ZERO;
        end
        else if (pick < 80)
        begin
            r.row_char = CH_ZERO + 8'($urandom_range(0, 9));
            r.col_char = CH_ZERO + 8'($urandom_range(0, 9));
        end
        else
        begin
            r.row_char = 8'($urandom());
            r.col_char = ($urandom_range(0, 1) == 0) ? 8'($urandom())
                                                     : CH_ZERO + 8'($urandom_range(0, 9));
        end

        pick = $urandom_range(0, 9);
        r.channel_char = (pick < 4) ? CH_BATTERY : (pick < 8) ? CH_TEMP : 8'($urandom());
        pick = $urandom_range(0, 9);
        r.value_char   = (pick < 4) ? CH_ZERO : (pick < 8) ? CH_ONE : 8'($urandom());
        return r;
    endfunction

    // Result checker: every accepted decision is compared with the oldest
    // prediction. Sampled at the rising edge, before the unit's registers move.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_decisions.size() == 0)
                report_mismatch("decision with no request pending");
            else
            begin
                want = pending_decisions.pop_front();
                check_field("action", {1'b0, out_ch.action}, {1'b0, want.action});
                check_field("forward_row", out_ch.forward_row, want.forward_row);
                check_field("forward_col", out_ch.forward_col, want.forward_col);
                check_field("battery_subscribed", {3'd0, out_ch.battery_subscribed},
                            {3'd0, want.battery_subscribed});
                check_field("temp_subscribed", {3'd0, out_ch.temp_subscribed},
                            {3'd0, want.temp_subscribed});
            end
        end
    end

    // Receiver: switches between always ready, random ready and runs of stall.
    // On request it holds off for a long stretch so that the unit backs up and
    // stalls its input side.
    initial
    begin
        int mode;
        int mode_left;
        int stall_left;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (mode)
                0: out_ch.ready = 1'b1;
                1: out_ch.ready = ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        out_ch.ready = 1'b0;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        stall_left   = $urandom_range(1, 12);
                        out_ch.ready = 1'b0;
                    end
                    else
                        out_ch.ready = 1'b1;
                end
            endcase
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Main sequence: reset, directed rows, then random phases under several
    // own-address settings (extremes included).
    initial
    begin
        directed_row_t row;
        logic [7:0]    cfg_high;
        logic [7:0]    cfg_low;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.src_addr     = '0;
        in_ch.seq_num      = '0;
        in_ch.kind_byte    = '0;
        in_ch.row_char     = '0;
        in_ch.col_char     = '0;
        in_ch.channel_char = '0;
        in_ch.value_char   = '0;
        mismatch_count     = 0;
        burst_left         = 0;
        hold_off_req       = 1'b0;
        refill_slot        = 0;
        battery_on         = 1'b0;
        temp_on            = 1'b0;
        node_high          = '0;
        node_low           = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            seen_sender[i] = '0;
            seen_seq[i]    = '0;
            seen_valid[i]  = 1'b0;
        end

        // Directed rows run with the reset address 0.0, so a command for
        // digits '0','0' is for this node. Senders 0x0000..0x0606 fill the
        // ten history slots; the next three evict the oldest ones.
        add_row(16'h0000, 8'h00, CH_FORWARD, CH_ZERO, CH_ZERO, CH_BATTERY, CH_ONE,
                1'b1, '{ACT_LOCAL, 4'd0, 4'd0, 1'b1, 1'b0});
        // Repeated sequence number: dropped, the clear command is not applied.
        add_row(16'h0000, 8'h00, CH_FORWARD, CH_ZERO, CH_ZERO, CH_BATTERY, CH_ZERO,
                1'b1, '{ACT_DUPLICATE, 4'd0, 4'd0, 1'b1, 1'b0});
        add_row(16'h0000, 8'h01, CH_FORWARD, CH_ZERO, CH_ZERO, CH_TEMP, CH_ONE,
                1'b1, '{ACT_LOCAL, 4'd0, 4'd0, 1'b1, 1'b1});
        add_row(16'hFFFF, 8'hFF, CH_FORWARD, 8'h39, 8'h39, 8'hFF, 8'hFF,
                1'b1, '{ACT_CHILD, 4'd9, 4'd9, 1'b1, 1'b1});
        add_row(16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                1'b1, '{ACT_DUPLICATE, 4'd0, 4'd0, 1'b1, 1'b1});
        add_row(16'h1234, 8'h10, 8'h00, 8'h33, 8'h34, CH_BATTERY, CH_ZERO,
                1'b1, '{ACT_PARENT, 4'd0, 4'd0, 1'b1, 1'b1});
        add_row(16'h5678, 8'h11, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                1'b1, '{ACT_PARENT, 4'd0, 4'd0, 1'b1, 1'b1});
        // Row character just below '0'.
        add_row(16'h0101, 8'h12, CH_FORWARD, 8'h2F, 8'h35, CH_BATTERY, CH_ONE,
                1'b1, '{ACT_BAD_CHILD, 4'd0, 4'd0, 1'b1, 1'b1});
        // Column digit value ten, one past the grid.
        add_row(16'h0202, 8'h13, CH_FORWARD, 8'h35, 8'h3A, CH_BATTERY, CH_ONE,
                1'b1, '{ACT_BAD_CHILD, 4'd0, 4'd0, 1'b1, 1'b1});
        add_row(16'h0303, 8'h14, CH_FORWARD, 8'hFF, 8'h00, CH_TEMP, CH_ZERO,
                1'b1, '{ACT_BAD_CHILD, 4'd0, 4'd0, 1'b1, 1'b1});
        // Local command with an unknown channel, then with an unknown value.
        add_row(16'h0404, 8'h2A, CH_FORWARD, CH_ZERO, CH_ZERO, 8'h58, CH_ONE,
                1'b1, '{ACT_LOCAL, 4'd0, 4'd0, 1'b1, 1'b1});
        add_row(16'h0505, 8'h16, CH_FORWARD, CH_ZERO, CH_ZERO, CH_BATTERY, 8'h32,
                1'b1, '{ACT_LOCAL, 4'd0, 4'd0, 1'b1, 1'b1});
        add_row(16'h0606, 8'h17, CH_FORWARD, CH_ZERO, CH_ZERO, CH_BATTERY, CH_ZERO,
                1'b1, '{ACT_LOCAL, 4'd0, 4'd0, 1'b0, 1'b1});
        add_row(16'h0707, 8'h18, CH_FORWARD, CH_ZERO, CH_ZERO, CH_TEMP, CH_ZERO,
                1'b1, '{ACT_LOCAL, 4'd0, 4'd0, 1'b0, 1'b0});
        add_row(16'h0808, 8'h19, CH_FORWARD, CH_ZERO, 8'h31, 8'h00, 8'h00,
                1'b1, '{ACT_CHILD, 4'd0, 4'd1, 1'b0, 1'b0});
        add_row(16'h0909, 8'h1A, CH_FORWARD, 8'h31, CH_ZERO, 8'hFF, 8'hFF,
                1'b1, '{ACT_CHILD, 4'd1, 4'd0, 1'b0, 1'b0});
        // Sender 0x0000 was evicted, so its old sequence number is new again.
        add_row(16'h0000, 8'h01, CH_FORWARD, CH_ZERO, CH_ZERO, CH_BATTERY, CH_ONE,
                1'b0, '0);
        // Still in the history: a true duplicate.
        add_row(16'h0404, 8'h2A, CH_FORWARD, CH_ZERO, CH_ZERO, CH_TEMP, CH_ONE,
                1'b0, '0);
        // Known sender with a fresh sequence number.
        add_row(16'h0505, 8'h55, CH_FORWARD, CH_ZERO, CH_ZERO, CH_TEMP, CH_ONE,
                1'b0, '0);
        add_row(16'hFFFF, 8'hFF, CH_FORWARD, CH_ZERO, CH_ZERO, CH_BATTERY, CH_ZERO,
                1'b0, '0);
        add_row(16'hAAAA, 8'h55, CH_FORWARD, 8'h39, 8'hFF, CH_BATTERY, CH_ONE,
                1'b0, '0);
        add_row(16'h5555, 8'hAA, CH_FORWARD, 8'h39, CH_ZERO, CH_BATTERY, CH_ONE,
                1'b0, '0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Registers must read back their reset value.
        check_register(REG_OWN_ADDR_HIGH, 8'd0);
        check_register(REG_OWN_ADDR_LOW, 8'd0);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_request(row.req, row.typed, row.want);
        end
        drain_decisions();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: begin cfg_high = 8'd0;   cfg_low = 8'd0;   end
                1: begin cfg_high = 8'd3;   cfg_low = 8'd7;   end
                2: begin cfg_high = 8'd255; cfg_low = 8'd255; end
                3: begin cfg_high = 8'd9;   cfg_low = 8'd9;   end
                4: begin cfg_high = 8'd0;   cfg_low = 8'd255; end
                5: begin cfg_high = 8'd255; cfg_low = 8'd0;   end
                default:
                begin
                    cfg_high = 8'($urandom_range(0, 9));
                    cfg_low  = 8'($urandom_range(0, 9));
                end
            endcase
            set_own_addr(cfg_high, cfg_low);
            foreach (sender_pool[i])
                sender_pool[i] = 16'($urandom());

            // In the second phase the receiver backs off for a long while
            // as the sender keeps pushing.
            if (phase == 1)
                hold_off_req = 1'b1;

            repeat (RANDOM_PER_PHASE)
                send_request(make_random_request(), 1'b0, '0);
            drain_decisions();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_decisions.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
